// ===== rtl/r2fftzp_pkg.sv =====
// Package for the zero-padded radix-2 FFT: store and output widths, default
// parameter values and the elaboration-time twiddle generator.
// No dependencies.
package r2fftzp_pkg;

  localparam int DEF_MAX_POINTS   = 64;
  localparam int DEF_SAMPLE_BITS  = 16;
  localparam int DEF_TWIDDLE_BITS = 16;
  localparam int STORE_BITS       = 24;
  localparam int OUT_BITS         = 22;
  localparam int BIN_BITS         = 6;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // cos(a) in Q30, a2 = a*a in Q30
  function automatic longint cos_q30(input logic [63:0] a2);
    logic [63:0] term;
    longint      sum;
    term = 64'd1 << 30;
    sum  = longint'(term);
    term = ((term * a2) >> 30) / 64'd2;   sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 64'd12;  sum = sum + longint'(term);
    term = ((term * a2) >> 30) / 64'd30;  sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 64'd56;  sum = sum + longint'(term);
    term = ((term * a2) >> 30) / 64'd90;  sum = sum - longint'(term);
    return sum;
  endfunction

  // sin(a) in Q30
  function automatic longint sin_q30(input logic [63:0] a, input logic [63:0] a2);
    logic [63:0] term;
    longint      sum;
    term = a;
    sum  = longint'(term);
    term = ((term * a2) >> 30) / 64'd6;   sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 64'd20;  sum = sum + longint'(term);
    term = ((term * a2) >> 30) / 64'd42;  sum = sum - longint'(term);
    term = ((term * a2) >> 30) / 64'd72;  sum = sum + longint'(term);
    term = ((term * a2) >> 30) / 64'd110; sum = sum - longint'(term);
    return sum;
  endfunction

  function automatic longint q30_to_tw(input longint q, input int tb);
    int     sh;
    longint v;
    sh = 30 - (tb - 1);
    v  = (q < 0) ? 64'sd0 : q;
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // Twiddle component for table entry e; angle t = e << sh on a 65536 circle.
  function automatic longint tw_calc(input int e, input int sh, input int tb,
                                     input bit want_im);
    logic [63:0] t;
    logic [63:0] a;
    logic [63:0] a2;
    bit          neg_cos;
    bit          swp;
    longint      c;
    longint      s;
    longint      tmp;
    t       = 64'(e) << sh;
    neg_cos = 1'b0;
    swp     = 1'b0;
    if (t >= 64'd16384) begin
      t       = 64'd32768 - t;
      neg_cos = 1'b1;
    end
    if (t > 64'd8192) begin
      t   = 64'd16384 - t;
      swp = 1'b1;
    end
    a  = (t * TWO_PI_Q30 + 64'd32768) >> 16;
    a2 = (a * a) >> 30;
    c  = cos_q30(a2);
    s  = sin_q30(a, a2);
    if (swp) begin
      tmp = c;
      c   = s;
      s   = tmp;
    end
    c = q30_to_tw(c, tb);
    s = q30_to_tw(s, tb);
    if (want_im) return -s;
    return neg_cos ? -c : c;
  endfunction

endpackage

// ===== rtl/r2fftzp_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module r2fftzp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/radix2_fft_zero_padded.sv =====
// Zero-padded radix-2 DIT FFT over frames of real samples.
// Depends on r2fftzp_pkg and r2fftzp_ram.
//
// Samples are taken one per cycle (in_stall low) until the transaction with
// in_frame_end set, which closes the frame. The frame is padded to the next
// power of two N, bit-reverse permuted, and run through log2(N) stages on a
// single butterfly unit with one 24 x 17 bit multiplier. In-place data lives
// in one RAM with one read and one write port. There are N/2*log2N butterflies;
// each reads q and p, runs its four partial products through the shared
// multiplier, accumulates, then writes p and q. Readout of each bin waits on
// out_stall. in_stall stays high from frame end until the last bin is taken.
// Frames longer than MAX_POINTS drop the excess samples and report
// out_overflowed on every bin.
module radix2_fft_zero_padded #(
  parameter int MAX_POINTS   = r2fftzp_pkg::DEF_MAX_POINTS,
  parameter int SAMPLE_BITS  = r2fftzp_pkg::DEF_SAMPLE_BITS,
  parameter int TWIDDLE_BITS = r2fftzp_pkg::DEF_TWIDDLE_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [SAMPLE_BITS-1:0]           in_sample,
  input  logic                                    in_frame_end,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [r2fftzp_pkg::BIN_BITS-1:0]        out_bin_index,
  output logic signed [r2fftzp_pkg::OUT_BITS-1:0] out_real_part,
  output logic signed [r2fftzp_pkg::OUT_BITS-1:0] out_imag_part,
  output logic                                    out_last_bin,
  output logic                                    out_overflowed
);
  import r2fftzp_pkg::*;

  localparam int DEPTH = 1 << $clog2(MAX_POINTS);
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = AW + 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int LGW   = $clog2(AW + 2);
  localparam int TWB   = TWIDDLE_BITS;
  localparam int FB    = TWB - 1;
  localparam int PW    = TWB + 1 + STORE_BITS;
  localparam int ACW   = PW + 1;
  localparam int WW    = 2 * STORE_BITS;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_PAD   = 12'b000000000010,
    ST_SWP   = 12'b000000000100,
    ST_BSET  = 12'b000000001000,
    ST_RQ    = 12'b000000010000,
    ST_RP    = 12'b000000100000,
    ST_MUL   = 12'b000001000000,
    ST_ACC   = 12'b000010000000,
    ST_WP    = 12'b000100000000,
    ST_WQ    = 12'b001000000000,
    ST_ORD   = 12'b010000000000,
    ST_OCAP  = 12'b100000000000
  } state_t;

  localparam logic signed [32:0] SMP_HI = 33'sd8388607;
  localparam logic signed [32:0] SMP_LO = -33'sd8388608;
  localparam logic signed [ACW-1:0] ST_HI = ACW'((64'sd1 <<< (STORE_BITS - 1)) - 1);
  localparam logic signed [ACW-1:0] ST_LO = -ACW'(64'sd1 <<< (STORE_BITS - 1));
  localparam logic signed [STORE_BITS-1:0] O_HI =
    STORE_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 1);
  localparam logic signed [STORE_BITS-1:0] O_LO = -STORE_BITS'(64'sd1 <<< (OUT_BITS - 1));
  localparam logic signed [ACW-1:0] HALF = ACW'(64'sd1 <<< (FB - 1));

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                drop_r, drop_nxt;
  logic [LGW-1:0]      lg_r, lg_nxt;
  logic [LGW-1:0]      stage_r, stage_nxt;
  logic [KW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       bfly_r, bfly_nxt;
  logic                swp_mode_r, swp_mode_nxt;
  logic [1:0]          mc_r, mc_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [AW-1:0]                p_r, q_r;
  logic signed [TWB:0]          twr_r, twi_r;
  logic [WW-1:0]                xq_r, u_r;
  logic signed [PW-1:0]         prod_r;
  logic signed [ACW-1:0]        acc_re_r, acc_im_r;
  logic [BIN_BITS-1:0]          obin_r;
  logic signed [OUT_BITS-1:0]   ore_r, oim_r;
  logic                         olast_r, oovf_r;

  logic signed [TWB:0] tw_re_tab [DEPTH];
  logic signed [TWB:0] tw_im_tab [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_tw
    localparam longint TWR = tw_calc(g % (DEPTH / 2), 16 - AW, TWB, 1'b0);
    localparam longint TWI = tw_calc(g % (DEPTH / 2), 16 - AW, TWB, 1'b1);
    assign tw_re_tab[g] = TWR[TWB:0];
    assign tw_im_tab[g] = TWI[TWB:0];
  end

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  r2fftzp_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Input sample clamp to store range
  logic signed [32:0]           samp_x;
  logic signed [STORE_BITS-1:0] samp_c;
  assign samp_x = 33'(in_sample);
  always_comb begin
    if (samp_x > SMP_HI) samp_c = SMP_HI[STORE_BITS-1:0];
    else if (samp_x < SMP_LO) samp_c = SMP_LO[STORE_BITS-1:0];
    else samp_c = samp_x[STORE_BITS-1:0];
  end

  logic          in_acc;
  logic [CW-1:0] cnt_new, cnt_m1;
  logic [LGW-1:0] lg_new;
  logic [KW-1:0] n_w;
  assign in_acc  = in_valid && !in_stall;
  assign cnt_new = (cnt_r < CW'(MAX_POINTS)) ? cnt_r + CW'(1) : cnt_r;
  assign cnt_m1  = cnt_new - CW'(1);
  always_comb begin
    lg_new = '0;
    for (int i = 0; i < CW; i++) begin
      if (cnt_m1[i]) lg_new = LGW'(i + 1);
    end
  end
  assign n_w = KW'(1) << lg_r;

  // Bit reversal of the permutation index
  logic [AW-1:0] rev_full, rev_idx;
  always_comb begin
    for (int b = 0; b < AW; b++) rev_full[b] = idx_r[AW-1-b];
  end
  assign rev_idx = rev_full >> (LGW'(AW) - lg_r);

  // Butterfly addressing
  logic [AW-1:0] h_w, j_w, p_w, e_w;
  assign h_w = AW'(1) << (stage_r - LGW'(1));
  assign j_w = bfly_r & (h_w - AW'(1));
  assign p_w = ((bfly_r >> (stage_r - LGW'(1))) << stage_r) | j_w;
  assign e_w = j_w << (LGW'(AW) - stage_r);

  // Shared multiplier
  logic signed [TWB:0]          opa;
  logic signed [STORE_BITS-1:0] opb;
  logic signed [STORE_BITS-1:0] xr, xi, ur, ui;
  assign xr  = xq_r[WW-1:STORE_BITS];
  assign xi  = xq_r[STORE_BITS-1:0];
  assign ur  = u_r[WW-1:STORE_BITS];
  assign ui  = u_r[STORE_BITS-1:0];
  assign opa = (mc_r == 2'd0 || mc_r == 2'd2) ? twr_r : twi_r;
  assign opb = (mc_r == 2'd0 || mc_r == 2'd3) ? xr : xi;

  logic signed [PW-1:0] mul_w;
  assign mul_w = PW'(opa) * PW'(opb);

  // Butterfly sums with saturation
  logic signed [ACW-1:0] tr_w, ti_w, sre_p, sim_p, sre_q, sim_q;
  assign tr_w  = acc_re_r >>> FB;
  assign ti_w  = acc_im_r >>> FB;
  assign sre_p = ACW'(ur) + tr_w;
  assign sim_p = ACW'(ui) + ti_w;
  assign sre_q = ACW'(ur) - tr_w;
  assign sim_q = ACW'(ui) - ti_w;

  function automatic logic [STORE_BITS-1:0] sat_st(input logic signed [ACW-1:0] v);
    if (v > ST_HI) return ST_HI[STORE_BITS-1:0];
    if (v < ST_LO) return ST_LO[STORE_BITS-1:0];
    return v[STORE_BITS-1:0];
  endfunction

  function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [STORE_BITS-1:0] v);
    if (v > O_HI) return O_HI[OUT_BITS-1:0];
    if (v < O_LO) return O_LO[OUT_BITS-1:0];
    return v[OUT_BITS-1:0];
  endfunction

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    lg_nxt        = lg_r;
    stage_nxt     = stage_r;
    idx_nxt       = idx_r;
    bfly_nxt      = bfly_r;
    swp_mode_nxt  = swp_mode_r;
    mc_nxt        = mc_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = p_r;
    ram_wdata     = '0;
    ram_raddr     = p_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_r < CW'(MAX_POINTS)) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_r[AW-1:0];
            ram_wdata = {samp_c, {STORE_BITS{1'b0}}};
          end else begin
            drop_nxt = 1'b1;
          end
          cnt_nxt = cnt_new;
          if (in_frame_end) begin
            lg_nxt    = lg_new;
            idx_nxt   = KW'(cnt_new);
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (idx_r < n_w) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r[AW-1:0];
          idx_nxt   = idx_r + KW'(1);
        end else begin
          idx_nxt      = '0;
          swp_mode_nxt = 1'b1;
          state_nxt    = ST_SWP;
        end
      end
      ST_SWP: begin
        if (idx_r == n_w) begin
          swp_mode_nxt = 1'b0;
          stage_nxt    = LGW'(1);
          bfly_nxt     = '0;
          state_nxt    = ST_BSET;
        end else if (rev_idx > idx_r[AW-1:0]) begin
          state_nxt = ST_RQ;
        end else begin
          idx_nxt = idx_r + KW'(1);
        end
      end
      ST_BSET: begin
        if (stage_r > lg_r) begin
          idx_nxt   = '0;
          state_nxt = ST_ORD;
        end else begin
          state_nxt = ST_RQ;
        end
      end
      ST_RQ: begin
        ram_raddr = q_r;
        state_nxt = ST_RP;
      end
      ST_RP: begin
        ram_raddr = p_r;
        mc_nxt    = 2'd0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        mc_nxt = mc_r + 2'd1;
        if (swp_mode_r) state_nxt = ST_WP;
        else if (mc_r == 2'd3) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = ST_WP;
      end
      ST_WP: begin
        ram_we    = 1'b1;
        ram_waddr = p_r;
        ram_wdata = swp_mode_r ? xq_r : {sat_st(sre_p), sat_st(sim_p)};
        state_nxt = ST_WQ;
      end
      ST_WQ: begin
        ram_we    = 1'b1;
        ram_waddr = q_r;
        ram_wdata = swp_mode_r ? u_r : {sat_st(sre_q), sat_st(sim_q)};
        if (swp_mode_r) begin
          idx_nxt   = idx_r + KW'(1);
          state_nxt = ST_SWP;
        end else begin
          if (KW'(bfly_r) == (n_w >> 1) - KW'(1)) begin
            bfly_nxt  = '0;
            stage_nxt = stage_r + LGW'(1);
          end else begin
            bfly_nxt = bfly_r + AW'(1);
          end
          state_nxt = ST_BSET;
        end
      end
      ST_ORD: begin
        if (!out_valid_r) begin
          ram_raddr = idx_r[AW-1:0];
          state_nxt = ST_OCAP;
        end else if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (olast_r) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + KW'(1);
          end
        end
      end
      ST_OCAP: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_ORD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      lg_r        <= '0;
      stage_r     <= '0;
      idx_r       <= '0;
      bfly_r      <= '0;
      swp_mode_r  <= 1'b0;
      mc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      lg_r        <= lg_nxt;
      stage_r     <= stage_nxt;
      idx_r       <= idx_nxt;
      bfly_r      <= bfly_nxt;
      swp_mode_r  <= swp_mode_nxt;
      mc_r        <= mc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_SWP) begin
      p_r <= idx_r[AW-1:0];
      q_r <= rev_idx;
    end
    if (state_r == ST_BSET) begin
      p_r   <= p_w;
      q_r   <= p_w | h_w;
      twr_r <= tw_re_tab[e_w];
      twi_r <= tw_im_tab[e_w];
    end
    if (state_r == ST_RP) begin
      xq_r <= ram_rdata;
    end
    if (state_r == ST_MUL) begin
      prod_r <= mul_w;
      case (mc_r)
        2'd0: u_r <= ram_rdata;
        2'd1: acc_re_r <= ACW'(prod_r) + HALF;
        2'd2: acc_re_r <= acc_re_r - ACW'(prod_r);
        2'd3: acc_im_r <= ACW'(prod_r) + HALF;
        default: u_r <= u_r;
      endcase
    end
    if (state_r == ST_ACC) begin
      acc_im_r <= acc_im_r + ACW'(prod_r);
    end
    if (state_r == ST_OCAP) begin
      obin_r  <= BIN_BITS'(idx_r);
      ore_r   <= sat_out(ram_rdata[WW-1:STORE_BITS]);
      oim_r   <= sat_out(ram_rdata[STORE_BITS-1:0]);
      olast_r <= (idx_r == n_w - KW'(1));
      oovf_r  <= drop_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin_index  = obin_r;
  assign out_real_part  = ore_r;
  assign out_imag_part  = oim_r;
  assign out_last_bin   = olast_r;
  assign out_overflowed = oovf_r;

`ifndef SYNTHESIS
  a_out_only_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_ORD))
    else $error("result valid outside readout");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_bin) |=> (cnt_r == '0 && !drop_r && !in_stall))
    else $error("frame state not cleared after last bin");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("sample count above capacity");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_frame_end) |=> (state_r == ST_PAD))
    else $error("frame end did not start the transform");
`endif

endmodule

// ===== tb/radix2_fft_zero_padded_test.sv =====
// Self-checking testbench for radix2_fft_zero_padded: frames of real samples go in,
// and every output bin is checked against a fixed-point FFT predictor kept in this file.
// Depends on r2fftzp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module radix2_fft_zero_padded_test;
  import r2fftzp_pkg::*;

  localparam int NPTS = DEF_MAX_POINTS;
  localparam int FRAC = DEF_TWIDDLE_BITS - 1;
  localparam longint TWO_PI_FX = 64'd6746518852;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int RANDOM_ITEMS = 60;

  typedef struct {
    logic [BIN_BITS-1:0]        bin;
    logic signed [OUT_BITS-1:0] re;
    logic signed [OUT_BITS-1:0] im;
    logic                       last;
    logic                       ovf;
  } bin_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [DEF_SAMPLE_BITS-1:0] in_sample;
  logic in_frame_end;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [BIN_BITS-1:0] out_bin_index;
  logic signed [OUT_BITS-1:0] out_real_part;
  logic signed [OUT_BITS-1:0] out_imag_part;
  logic out_last_bin;
  logic out_overflowed;

  bin_t   spectrum_q[$];
  longint buf_re[2*NPTS];
  longint buf_im[2*NPTS];
  int     held;
  bit     dropped;
  int     errors = 0;
  int     items_sent;
  bit     no_idle;
  int     hold_asked;
  int     hold_done = 0;
  int     hold_left = 0;
  int     quiet_cycles = 0;

  radix2_fft_zero_padded u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample(in_sample), .in_frame_end(in_frame_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bin_index(out_bin_index), .out_real_part(out_real_part),
    .out_imag_part(out_imag_part), .out_last_bin(out_last_bin),
    .out_overflowed(out_overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat(input longint v, input int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint series_q30(input longint first, input longint a2, input longint k0);
    longint term;
    longint acc;
    longint k;
    term = first;
    acc  = first;
    k    = k0;
    for (int n = 0; n < 5; n++) begin
      term = ((term * a2) >>> 30) / (k * (k + 1));
      acc  = (n % 2 == 1) ? acc + term : acc - term;
      k    = k + 2;
    end
    return acc;
  endfunction

  function automatic longint q30_round(input longint q);
    int sh;
    sh = 30 - FRAC;
    if (q < 0) q = 0;
    return (q + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  task automatic rotation(input int j, input int m, output longint wr, output longint wi);
    longint ang;
    longint a;
    longint a2;
    longint c;
    longint s;
    longint tmp;
    bit     flip;
    bit     swp;
    ang  = (longint'(j) * 65536) / m;
    flip = 1'b0;
    swp  = 1'b0;
    if (ang >= 16384) begin
      ang  = 32768 - ang;
      flip = 1'b1;
    end
    if (ang > 8192) begin
      ang = 16384 - ang;
      swp = 1'b1;
    end
    a  = (ang * TWO_PI_FX + 32768) >>> 16;
    a2 = (a * a) >>> 30;
    c  = series_q30(64'sd1 <<< 30, a2, 1);
    s  = series_q30(a, a2, 2);
    if (swp) begin
      tmp = c;
      c   = s;
      s   = tmp;
    end
    c  = q30_round(c);
    s  = q30_round(s);
    wr = flip ? -c : c;
    wi = -s;
  endtask

  task automatic compute_spectrum();
    int     n;
    int     lg;
    int     r;
    int     p;
    int     q;
    longint wr;
    longint wi;
    longint tr;
    longint ti;
    longint ur;
    longint ui;
    longint tmp;
    bin_t   b;
    n  = 1;
    lg = 0;
    while (n < held) begin
      n  = n * 2;
      lg = lg + 1;
    end
    for (int k = held; k < n; k++) begin
      buf_re[k] = 0;
      buf_im[k] = 0;
    end
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int bt = 0; bt < lg; bt++) r = (r << 1) | ((i >> bt) & 1);
      if (r > i) begin
        tmp = buf_re[i]; buf_re[i] = buf_re[r]; buf_re[r] = tmp;
        tmp = buf_im[i]; buf_im[i] = buf_im[r]; buf_im[r] = tmp;
      end
    end
    for (int m = 2; m <= n; m = m * 2) begin
      for (int j = 0; j < m / 2; j++) begin
        rotation(j, m, wr, wi);
        for (int k = 0; k + m <= n; k += m) begin
          p  = k + j;
          q  = p + m / 2;
          tr = (wr * buf_re[q] - wi * buf_im[q] + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
          ti = (wr * buf_im[q] + wi * buf_re[q] + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
          ur = buf_re[p];
          ui = buf_im[p];
          buf_re[p] = sat(ur + tr, STORE_BITS);
          buf_im[p] = sat(ui + ti, STORE_BITS);
          buf_re[q] = sat(ur - tr, STORE_BITS);
          buf_im[q] = sat(ui - ti, STORE_BITS);
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      b.bin  = k[BIN_BITS-1:0];
      b.re   = OUT_BITS'(sat(buf_re[k], OUT_BITS));
      b.im   = OUT_BITS'(sat(buf_im[k], OUT_BITS));
      b.last = (k == n - 1);
      b.ovf  = dropped;
      spectrum_q = {spectrum_q, b};
    end
    held    = 0;
    dropped = 1'b0;
  endtask

  task automatic absorb_sample(input logic signed [DEF_SAMPLE_BITS-1:0] s, input bit fe);
    if (held < NPTS) begin
      buf_re[held] = longint'(s);
      buf_im[held] = 0;
      held++;
    end else begin
      dropped = 1'b1;
    end
    if (fe) compute_spectrum();
  endtask

  task automatic send_sample(input logic signed [DEF_SAMPLE_BITS-1:0] s, input bit fe);
    if (!no_idle && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_frame_end <= fe;
    absorb_sample(s, fe);
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  function automatic logic signed [DEF_SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 63)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (spectrum_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'shffff, 1'b0);
    send_sample(16'sh5555, 1'b1);
    send_frame(5);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'shaaaa, 1'b1);
    drain();
  endtask

  task automatic test_full_scale();
    no_idle = 1'b1;
    for (int i = 0; i < NPTS; i++) send_sample((i % 2) ? 16'sh8000 : 16'sh7fff, i == NPTS - 1);
    drain();
    no_idle = 1'b0;
  endtask

  task automatic test_overflow();
    send_frame(NPTS + 2);
    drain();
  endtask

  task automatic test_backpressure();
    hold_asked++;
    send_frame(9);
    send_frame(4);
    send_frame(3);
    drain();
  endtask

  task automatic test_random();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(9) == 0) send_frame($urandom_range(NPTS - 4, NPTS + 6));
      else send_frame($urandom_range(1, 16));
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (spectrum_q.size() == 0) begin
        $error("unexpected bin %0d", out_bin_index);
        errors++;
      end else begin
        bin_t e;
        e = spectrum_q.pop_front();
        if (out_bin_index !== e.bin) begin
          $error("bin_index exp %0d got %0d", e.bin, out_bin_index); errors++;
        end
        if (out_real_part !== e.re) begin
          $error("real_part exp %0d got %0d", e.re, out_real_part); errors++;
        end
        if (out_imag_part !== e.im) begin
          $error("imag_part exp %0d got %0d", e.im, out_imag_part); errors++;
        end
        if (out_last_bin !== e.last) begin
          $error("last_bin exp %0d got %0d", e.last, out_last_bin); errors++;
        end
        if (out_overflowed !== e.ovf) begin
          $error("overflowed exp %0d got %0d", e.ovf, out_overflowed); errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_asked != hold_done) begin
      hold_done <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(99) < 26);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("radix2_fft_zero_padded regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    in_frame_end = 1'b0;
    held         = 0;
    dropped      = 1'b0;
    items_sent   = 0;
    no_idle      = 1'b0;
    hold_asked   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_scale();
    test_overflow();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    repeat (100) @(posedge clk);
    if (errors == 0 && spectrum_q.size() == 0) begin
      $display("radix2_fft_zero_padded regression: pass");
    end else begin
      $display("radix2_fft_zero_padded regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/r2fftzp_pkg.sv
rtl/r2fftzp_ram.sv
rtl/radix2_fft_zero_padded.sv
tb/radix2_fft_zero_padded_test.sv
